// ===== src/metronome_click_mixer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Metronome click mixer assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef METRONOME_CLICK_MIXER_TOP_ASSERT_SVH
`define METRONOME_CLICK_MIXER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge out of reset
`define MCM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCM_ASSERT_ALWAYS(lbl, cond, msg)
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int CFRAC      = 30;
    localparam int INC_W      = 32;
    localparam int GAIN_W     = 30;
    localparam int A1_W       = 32;
    localparam int A2_W       = 30;
    localparam int BEAT_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 64;
    // quotient width after dropping the fractional bits of the accumulator
    localparam int Q_W        = ACC_W - CFRAC;
    // right shift from filter format to audio format (positive at these sizes)
    localparam int MIX_SH     = CFRAC - (SAMPLE_W - 1);
    localparam int CLICK_W    = COEF_W + 1 - MIX_SH;
    localparam int SUM_W      = CLICK_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEAT_INCREMENT = 8'd0,
        CFG_CLICK_GAIN     = 8'd1,
        CFG_RESONATOR_A1   = 8'd2,
        CFG_RESONATOR_A2   = 8'd3
    } t_cfg_idx;

    localparam logic [INC_W-1:0]         RST_BEAT_INCREMENT = 32'd0;
    localparam logic [GAIN_W-1:0]        RST_CLICK_GAIN     = 30'd10737418;
    localparam logic signed [A1_W-1:0]   RST_RESONATOR_A1   = -32'sd2122992671;
    localparam logic [A2_W-1:0]          RST_RESONATOR_A2   = 30'd1067578546;

    typedef struct packed {
        logic [INC_W-1:0]  beat_increment;
        logic [GAIN_W-1:0] click_gain;
        logic [A1_W-1:0]   resonator_a1;
        logic [A2_W-1:0]   resonator_a2;
    } t_cfg;

    typedef struct packed {
        logic              tick;
        logic [BEAT_W-1:0] whole;
        logic [BEAT_W-1:0] frac;
    } t_beat_pos;

endpackage

`default_nettype wire

// ===== src/mcm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer configuration registers
// Holds beat increment, click gain and resonator coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [mcm_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [mcm_pkg::CFG_DATA_W-1:0] i_data,
    output mcm_pkg::t_cfg                       o_cfg
);
    import mcm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_BEAT_INCREMENT: n_cfg.beat_increment = i_data[INC_W-1:0];
                CFG_CLICK_GAIN:     n_cfg.click_gain     = i_data[GAIN_W-1:0];
                CFG_RESONATOR_A1:   n_cfg.resonator_a1   = i_data[A1_W-1:0];
                CFG_RESONATOR_A2:   n_cfg.resonator_a2   = i_data[A2_W-1:0];
                default:            n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beat_increment <= RST_BEAT_INCREMENT;
            r_cfg.click_gain     <= RST_CLICK_GAIN;
            r_cfg.resonator_a1   <= RST_RESONATOR_A1;
            r_cfg.resonator_a2   <= RST_RESONATOR_A2;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/mcm_beat_phase.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer beat phase
// Q32.32 beat accumulator with a carry flag that marks the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_beat_phase (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire logic [mcm_pkg::INC_W-1:0] i_increment,
    output mcm_pkg::t_beat_pos             o_pos
);
    import mcm_pkg::*;

    logic [BEAT_W-1:0] r_whole;
    logic [BEAT_W-1:0] r_frac;
    logic              r_carry;
    logic [BEAT_W:0]   w_next;

    // increment is a pure fraction, so at most one carry per sample
    assign w_next = {1'b0, r_frac} + (BEAT_W + 1)'(i_increment);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole <= '0;
            r_frac  <= '0;
            r_carry <= 1'b0;
        end else if (i_advance) begin
            r_frac  <= w_next[BEAT_W-1:0];
            r_carry <= w_next[BEAT_W];
            r_whole <= r_whole + BEAT_W'(w_next[BEAT_W]);
        end
    end

    assign o_pos.tick  = r_carry;
    assign o_pos.whole = r_whole;
    assign o_pos.frac  = r_frac;

endmodule

`default_nettype wire

// ===== src/mcm_resonator.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer resonator
// Two-pole section y = g*x - a1*z1 - a2*z2, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_resonator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic                       i_tick,
    input  wire mcm_pkg::t_cfg              i_cfg,
    output logic signed [mcm_pkg::COEF_W-1:0] o_y
);
    import mcm_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (CFRAC - 1);

    logic signed [COEF_W-1:0]          r_z1;
    logic signed [COEF_W-1:0]          r_z2;
    logic signed [COEF_W-1:0]          n_y;
    logic signed [ACC_W-1:0]           w_gterm;
    logic signed [A1_W+COEF_W-1:0]     w_p1;
    logic signed [A2_W+COEF_W:0]       w_p2;
    logic signed [ACC_W-1:0]           w_acc;
    logic signed [ACC_W-1:0]           w_rnd;
    logic        [Q_W-1:0]             w_q;
    logic        [Q_W-COEF_W:0]        w_top;
    logic                              w_ovf;

    // impulse enters only on the tick sample
    assign w_gterm = i_tick ?
        $signed({{(ACC_W-GAIN_W-CFRAC){1'b0}}, i_cfg.click_gain, {CFRAC{1'b0}}}) : '0;
    assign w_p1  = $signed(i_cfg.resonator_a1) * r_z1;
    assign w_p2  = $signed({1'b0, i_cfg.resonator_a2}) * r_z2;
    assign w_acc = w_gterm - ACC_W'(w_p1) - ACC_W'(w_p2);
    assign w_rnd = w_acc + HALF;
    assign w_q   = w_rnd[ACC_W-1:CFRAC];
    assign w_top = w_q[Q_W-1:COEF_W-1];
    assign w_ovf = !((&w_top) || !(|w_top));

    always_comb begin
        if (w_ovf) begin
            n_y = w_q[Q_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            n_y = w_q[COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= '0;
            r_z2 <= '0;
        end else if (i_advance) begin
            r_z1 <= n_y;
            r_z2 <= r_z1;
        end
    end

    // z1 holds the output of the last accepted sample
    assign o_y = r_z1;

endmodule

`default_nettype wire

// ===== src/mcm_mixer.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer output mix
// Rounds the resonator output to audio format and adds it with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_mixer (
    input  wire logic signed [mcm_pkg::COEF_W-1:0]   i_y,
    input  wire logic signed [mcm_pkg::SAMPLE_W-1:0] i_audio,
    output logic signed [mcm_pkg::SAMPLE_W-1:0]      o_mixed
);
    import mcm_pkg::*;

    localparam logic signed [COEF_W:0] HALF = (COEF_W + 1)'(1) << (MIX_SH - 1);

    logic signed [COEF_W:0]       w_rnd;
    logic signed [CLICK_W-1:0]    w_click;
    logic signed [SUM_W-1:0]      w_sum;
    logic [SUM_W-SAMPLE_W:0]      w_top;
    logic                         w_ovf;

    assign w_rnd   = (COEF_W + 1)'(i_y) + HALF;
    assign w_click = w_rnd[COEF_W:MIX_SH];
    assign w_sum   = SUM_W'(w_click) + SUM_W'(i_audio);
    assign w_top   = w_sum[SUM_W-1:SAMPLE_W-1];
    assign w_ovf   = !((&w_top) || !(|w_top));

    always_comb begin
        if (w_ovf) begin
            o_mixed = w_sum[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            o_mixed = w_sum[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/metronome_click_mixer_top.sv =====
// ----------------------------------------------------------------------------
// Metronome click mixer
// Beat phase accumulator driving a resonant click mixed into audio.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_audio_in
//  output    out        o_valid / i_ready         o_mixed_sample, o_tick,
//                                                 o_beat_whole, o_beat_frac
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One sample per cycle unless stalled; registered in stage one, then at the output.
//  The resonator multiply-add and its state update happen in the accept cycle;
//  rounding and the saturating mix happen in the stage before the result register.
//  Synchronous active-low reset clears beat phase, filter state and valid flags.
//  A stalled result holds while the stage behind it keeps taking one more request.
// ----------------------------------------------------------------------------
`default_nettype none

module metronome_click_mixer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [mcm_pkg::SAMPLE_W-1:0] i_audio_in,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [mcm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                                o_tick,
    output logic [mcm_pkg::BEAT_W-1:0]          o_beat_whole,
    output logic [mcm_pkg::BEAT_W-1:0]          o_beat_frac,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mcm_pkg::*;

    `include "metronome_click_mixer_top_assert.svh"

    t_cfg                     w_cfg;
    t_beat_pos                w_pos;
    logic signed [COEF_W-1:0] w_y;
    logic signed [SAMPLE_W-1:0] w_mixed;
    logic                     w_in_acc;
    logic                     w_out_load;

    logic                     r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_audio;
    t_beat_pos                r_s1_pos;
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_mixed;
    t_beat_pos                r_out_pos;

    assign o_cfg_ready = 1'b1;

    mcm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_out_load = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || w_out_load;
    assign w_in_acc   = i_valid && o_ready;

    mcm_beat_phase u_beat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_in_acc),
        .i_increment (w_cfg.beat_increment),
        .o_pos       (w_pos)
    );

    mcm_resonator u_res (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_in_acc),
        .i_tick    (w_pos.tick),
        .i_cfg     (w_cfg),
        .o_y       (w_y)
    );

    // w_y is the filter output of the request held in stage one
    mcm_mixer u_mix (
        .i_y     (w_y),
        .i_audio (r_s1_audio),
        .o_mixed (w_mixed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_audio <= i_audio_in;
            r_s1_pos   <= w_pos;
        end
        if (w_out_load && r_s1_valid) begin
            r_out_mixed <= w_mixed;
            r_out_pos   <= r_s1_pos;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_out_mixed;
    assign o_tick         = r_out_pos.tick;
    assign o_beat_whole   = r_out_pos.whole;
    assign o_beat_frac    = r_out_pos.frac;

    `MCM_ASSERT_NEXT(a_accept_fills_s1, i_rst_n && w_in_acc, r_s1_valid, "request lost after accept")
    `MCM_ASSERT_NEXT(a_phase_holds, !w_in_acc, $stable(w_pos), "beat phase moved without a request")
    `MCM_ASSERT_NEXT(a_filter_holds, !w_in_acc, $stable(w_y), "filter state moved without a request")
    `MCM_ASSERT_ALWAYS(a_no_accept_when_full, !(r_s1_valid && r_out_valid && !i_ready) || !o_ready,
                       "request taken while both stages are stalled")

endmodule

`default_nettype wire
